FILE: hdl/joint_trajectory_chunk_checker_assert.svh
// assertion macros for the trajectory chunk checker
`ifndef JOINT_TRAJECTORY_CHUNK_CHECKER_ASSERT_SVH
`define JOINT_TRAJECTORY_CHUNK_CHECKER_ASSERT_SVH
`ifndef SYNTH
`define JTCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define JTCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define JTCC_ASSERT_IMP(lbl, ante, cons)
`define JTCC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/jtcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package jtcc_pkg;
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;
  localparam int FLAG_WF = 0;
  localparam int FLAG_JV = 1;
  localparam int FLAG_RV = 2;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [31:0] RATIO_SAT = 32'hFFFF_FFFF;
  typedef logic [31:0] q16_t;
endpackage
`default_nettype wire

FILE: hdl/joint_trajectory_chunk_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Trajectory chunk checker. Load requests (kind 0) store one joint's measured
// position and velocity limit without leaving the idle state, so loads can
// follow each other with no gap. A sample request (kind 1) holds in_stall
// until it is done: the accept cycle, a memory read step, a multiply step, an
// overflow-check step and a restoring divider that makes the Q16.16
// speed-to-limit ratio one quotient bit per cycle, then an update cycle.
// Samples that need no ratio go from the read straight to the update, and a
// ratio whose quotient overflows skips the divider. The references and the
// previous point's positions live in synchronous memories, so no clearing pass
// follows reset. The final sample of a chunk delivers one result request;
// the block keeps taking requests while that result waits, and a second chunk
// end holds in its update cycle until the first result leaves.
module joint_trajectory_chunk_checker #(
  parameter int MAX_JOINTS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_write,
  input  wire  [5:0]  cfg_joint_count,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_kind,
  input  wire  [4:0]  in_joint_index,
  input  wire  signed [31:0] in_position,
  input  wire  [30:0] in_limit_value,
  input  wire  [31:0] in_point_time_us,
  input  wire         in_last_in_point,
  input  wire         in_last_in_chunk,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_well_formed,
  output logic        out_jump_valid,
  output logic [31:0] out_start_jump,
  output logic [31:0] out_max_step,
  output logic        out_ratio_valid,
  output logic [31:0] out_max_ratio
);

  localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam logic [6:0] MAXJ = 7'(MAX_JOINTS);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_PRE  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    begin
      d = $signed({a[31], a}) - $signed({b[31], b});
      abs_diff = d[32] ? 32'(-d) : d[31:0];
    end
  endfunction

  // per-joint memories
  logic [31:0] ref_mem  [MAX_JOINTS];
  logic [30:0] lim_mem  [MAX_JOINTS];
  logic [31:0] prev_mem [MAX_JOINTS];
  logic [31:0] ref_q, prev_q;
  logic [30:0] lim_q;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  jc_r;
  logic [MAX_JOINTS-1:0] loaded_r, limpos_r;
  logic [31:0] prev_time_r, cur_time_r;
  logic [5:0]  cnt_smp_r;
  logic        first_r;
  logic [31:0] worst_jump_r, worst_step_r, worst_ratio_r;
  logic [2:0]  flags_r;

  // per-sample context latched at accept
  logic [AW-1:0] addr_r;
  logic        in_rng_r, s_first_r, s_loaded_r, s_limited_r, s_end_r, dt_pos_r;
  logic [31:0] pos_r, dt_r, dp_r;
  logic [51:0] num_r;
  logic [62:0] den_r, rem_r;
  logic [31:0] quo_r;
  logic [4:0]  bit_r;

  logic        accept, is_sample, in_rng, t_new;
  logic [5:0]  j;
  logic [6:0]  j_ext;
  logic [AW-1:0] j_addr, ld_addr;
  logic [31:0] cur_new, d_sel;
  logic [31:0] dvd_lo;
  logic [63:0] rem_sh;
  logic        rem_ge;
  logic [31:0] quo_nxt;
  logic [MAX_JOINTS-1:0] need;
  logic        fits, jv, rv;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign is_sample = (in_kind == jtcc_pkg::KIND_SAMPLE);
  assign j         = cnt_smp_r;
  assign j_ext     = {1'b0, j};
  assign j_addr    = j_ext[AW-1:0];
  assign ld_addr   = AW'({2'b00, in_joint_index});
  assign in_rng    = (j < jc_r) && (j_ext < MAXJ);
  assign cur_new   = (j == 6'd0) ? in_point_time_us : cur_time_r;
  assign t_new     = cur_new > prev_time_r;
  assign d_sel     = abs_diff(pos_r, s_first_r ? ref_q : prev_q);
  // low dividend bits: the numerator's low 16 bits, then the 16 fraction zeros
  assign dvd_lo    = {num_r[15:0], 16'h0000};
  assign rem_sh    = {rem_r, dvd_lo[bit_r]};
  assign rem_ge    = rem_sh >= {1'b0, den_r};
  assign quo_nxt   = {quo_r[30:0], rem_ge};
  assign fits      = {1'b0, jc_r} <= MAXJ;

  always_comb begin
    for (int i = 0; i < MAX_JOINTS; i++) begin
      need[i] = (7'(i) < {1'b0, jc_r});
    end
  end
  assign jv = fits && flags_r[jtcc_pkg::FLAG_JV] && ((loaded_r & need) == need);
  assign rv = jv && flags_r[jtcc_pkg::FLAG_RV] && ((limpos_r & need) == need);

  // memory ports
  always_ff @(posedge clk) begin
    if (accept && !is_sample && ({2'b00, in_joint_index} < MAXJ)) begin
      ref_mem[ld_addr] <= in_position;
      lim_mem[ld_addr] <= in_limit_value;
    end
    if (accept && is_sample) begin
      ref_q  <= ref_mem[j_addr];
      lim_q  <= lim_mem[j_addr];
      prev_q <= prev_mem[j_addr];
    end
    if (state_r == S_RD && in_rng_r) begin
      prev_mem[addr_r] <= pos_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept && is_sample) state_nxt = S_RD;
      S_RD: begin
        if (in_rng_r && s_limited_r && dt_pos_r) state_nxt = S_MUL;
        else state_nxt = S_FIN;
      end
      S_MUL: state_nxt = S_PRE;
      S_PRE: begin
        if ({28'd0, num_r[51:16]} >= {1'b0, den_r}) state_nxt = S_FIN;
        else state_nxt = S_DIV;
      end
      S_DIV: if (bit_r == 5'd0) state_nxt = S_FIN;
      S_FIN: if (!(s_end_r && out_valid && out_stall)) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // payload registers of the datapath
  always_ff @(posedge clk) begin
    if (accept && is_sample) begin
      addr_r      <= j_addr;
      in_rng_r    <= in_rng;
      s_first_r   <= first_r;
      s_loaded_r  <= loaded_r[j_addr];
      s_limited_r <= loaded_r[j_addr] && limpos_r[j_addr];
      s_end_r     <= in_last_in_chunk;
      pos_r       <= in_position;
      dt_pos_r    <= t_new;
      dt_r        <= cur_new - prev_time_r;
    end
    if (state_r == S_RD) dp_r <= d_sel;
    if (state_r == S_MUL) begin
      num_r <= {20'd0, dp_r} * {32'd0, jtcc_pkg::USEC_PER_SEC};
      den_r <= {31'd0, dt_r} * {32'd0, lim_q};
    end
    if (state_r == S_PRE) begin
      rem_r <= 63'(num_r[51:16]);
      bit_r <= 5'd31;
      quo_r <= '0;
    end
    if (state_r == S_DIV) begin
      rem_r <= rem_ge ? 63'(rem_sh - {1'b0, den_r}) : rem_sh[62:0];
      quo_r <= quo_nxt;
      bit_r <= bit_r - 5'd1;
    end
  end

  // control and chunk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      jc_r          <= '0;
      loaded_r      <= '0;
      limpos_r      <= '0;
      prev_time_r   <= '0;
      cur_time_r    <= '0;
      cnt_smp_r     <= '0;
      first_r       <= 1'b1;
      worst_jump_r  <= '0;
      worst_step_r  <= '0;
      worst_ratio_r <= '0;
      flags_r       <= 3'b111;
      out_valid     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write) jc_r <= cfg_joint_count;

      if (accept && !is_sample && ({2'b00, in_joint_index} < MAXJ)) begin
        loaded_r[ld_addr] <= 1'b1;
        limpos_r[ld_addr] <= (in_limit_value != '0);
      end

      if (accept && is_sample) begin
        logic [2:0] fl;
        logic [5:0] cn;
        fl = flags_r;
        cn = (j < 6'd63) ? j + 6'd1 : j;
        if (j == 6'd0 && !t_new) fl[jtcc_pkg::FLAG_WF] = 1'b0;
        if (!in_rng) fl[jtcc_pkg::FLAG_WF] = 1'b0;
        else begin
          if (!loaded_r[j_addr]) fl[jtcc_pkg::FLAG_JV] = 1'b0;
          if (!(loaded_r[j_addr] && limpos_r[j_addr])) fl[jtcc_pkg::FLAG_RV] = 1'b0;
        end
        cur_time_r <= cur_new;
        cnt_smp_r  <= cn;
        if (in_last_in_point || in_last_in_chunk) begin
          if (cn != jc_r) fl[jtcc_pkg::FLAG_WF] = 1'b0;
          cnt_smp_r <= '0;
          if (in_last_in_chunk) begin
            // chunk restarts its timing here, worst values clear at the result
            prev_time_r <= '0;
            cur_time_r  <= '0;
            first_r     <= 1'b1;
          end else begin
            prev_time_r <= cur_new;
            first_r     <= 1'b0;
          end
        end
        flags_r <= fl;
      end

      if (state_r == S_RD && in_rng_r) begin
        if (s_first_r && s_loaded_r && d_sel > worst_jump_r) worst_jump_r <= d_sel;
        if (!s_first_r && d_sel > worst_step_r) worst_step_r <= d_sel;
        if (s_limited_r && !dt_pos_r) worst_ratio_r <= jtcc_pkg::RATIO_SAT;
      end
      // quotient overflow saturates
      if (state_r == S_PRE && state_nxt == S_FIN) worst_ratio_r <= jtcc_pkg::RATIO_SAT;
      if (state_r == S_DIV && bit_r == 5'd0 && quo_nxt > worst_ratio_r) begin
        worst_ratio_r <= quo_nxt;
      end

      // a new result may replace one that leaves at this edge
      if (state_r == S_FIN && s_end_r && !(out_valid && out_stall)) begin
        out_valid       <= 1'b1;
        out_well_formed <= flags_r[jtcc_pkg::FLAG_WF] && (jc_r != '0) && fits;
        out_jump_valid  <= jv;
        out_start_jump  <= jv ? worst_jump_r : '0;
        out_max_step    <= worst_step_r;
        out_ratio_valid <= rv;
        out_max_ratio   <= rv ? worst_ratio_r : '0;
        worst_jump_r    <= '0;
        worst_step_r    <= '0;
        worst_ratio_r   <= '0;
        flags_r         <= 3'b111;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`include "joint_trajectory_chunk_checker_assert.svh"
  `JTCC_ASSERT_NXT(a_sample_busy, accept && is_sample, state_r == S_RD)
  `JTCC_ASSERT_NXT(a_result_out, state_r == S_FIN && s_end_r && !(out_valid && out_stall), out_valid)
  `JTCC_ASSERT_IMP(a_ratio_zero, out_valid && !out_ratio_valid, out_max_ratio == '0)
  `JTCC_ASSERT_IMP(a_jump_zero, out_valid && !out_jump_valid, out_start_jump == '0)

endmodule
`default_nettype wire
